// ===== rtl/rlct_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the RGB LED chain transmitter.
package rlct_pkg;

    localparam int NUM_LEDS_DEF = 128;
    localparam int ROW_W        = 24;
    localparam int CNT_W        = 16;
    localparam int CFG_W        = 16;
    localparam int BIT_CNT_W    = 5;

    localparam logic [BIT_CNT_W-1:0] BIT_LAST = 5'd23;

    localparam logic [7:0]  BIT_PERIOD_RST = 8'd21;
    localparam logic [7:0]  ZERO_HIGH_RST  = 8'd6;
    localparam logic [7:0]  ONE_HIGH_RST   = 8'd15;
    localparam logic [15:0] LATCH_RST      = 16'd4480;

    typedef enum logic [1:0] {
        CMD_SET    = 2'd0,
        CMD_CLEAR  = 2'd1,
        CMD_UPDATE = 2'd2,
        CMD_TICK   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        CFG_BIT_PERIOD = 2'd0,
        CFG_ZERO_HIGH  = 2'd1,
        CFG_ONE_HIGH   = 2'd2,
        CFG_LATCH      = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        TX_IDLE  = 2'd0,
        TX_BITS  = 2'd1,
        TX_LATCH = 2'd2
    } tx_phase_t;

    typedef struct packed {
        logic [7:0]  bit_period;
        logic [7:0]  zero_high;
        logic [7:0]  one_high;
        logic [15:0] latch;
    } timing_t;

    typedef struct packed {
        logic start;
        logic tick;
    } tx_ctrl_t;

    typedef struct packed {
        logic active;
        logic active_next;
        logic pin_next;
    } tx_status_t;

endpackage

// ===== rtl/rlct_frame_mem.sv =====
`timescale 1ns / 1ps
// Frame buffer memory: one GRB row per LED, registered read with write forwarding.
module rlct_frame_mem #(
    parameter int DEPTH = rlct_pkg::NUM_LEDS_DEF
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [rlct_pkg::ROW_W-1:0]                 wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [rlct_pkg::ROW_W-1:0]                 rdata
);

    logic [rlct_pkg::ROW_W-1:0] mem [DEPTH];
    logic [rlct_pkg::ROW_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we && (waddr == raddr))
        begin
            rdata_reg <= wdata;
        end
        else
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/rlct_tx.sv =====
`timescale 1ns / 1ps
// Serializer: bit timing, latch period and row prefetch from the frame buffer.
module rlct_tx #(
    parameter int NUM_LEDS = rlct_pkg::NUM_LEDS_DEF
) (
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  rlct_pkg::tx_ctrl_t                               ctrl,
    input  rlct_pkg::timing_t                                timing,
    input  logic [rlct_pkg::ROW_W-1:0]                       row_data,
    output logic [(NUM_LEDS > 1 ? $clog2(NUM_LEDS) : 1)-1:0] rd_addr,
    output rlct_pkg::tx_status_t                             status
);

    localparam int AW = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
    localparam logic [AW-1:0] LED_LAST = AW'(NUM_LEDS - 1);

    rlct_pkg::tx_phase_t                phase_reg, phase_next;
    logic [AW-1:0]                      led_reg, led_next;
    logic [rlct_pkg::BIT_CNT_W-1:0]     bit_reg, bit_next;
    logic [rlct_pkg::CNT_W-1:0]         cnt_reg, cnt_next;
    logic [rlct_pkg::ROW_W-1:0]         row_reg, row_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= rlct_pkg::TX_IDLE;
            led_reg   <= '0;
            bit_reg   <= '0;
            cnt_reg   <= '0;
            row_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            led_reg   <= led_next;
            bit_reg   <= bit_next;
            cnt_reg   <= cnt_next;
            row_reg   <= row_next;
        end
    end

    always_comb
    begin
        logic [rlct_pkg::CNT_W:0] cnt_inc;
        logic [7:0]               high;
        cnt_inc    = {1'b0, cnt_reg} + 17'd1;
        phase_next = phase_reg;
        led_next   = led_reg;
        bit_next   = bit_reg;
        cnt_next   = cnt_reg;
        row_next   = row_reg;
        case (phase_reg)
            rlct_pkg::TX_IDLE:
            begin
                if (ctrl.start)
                begin
                    phase_next = rlct_pkg::TX_BITS;
                    led_next   = '0;
                    bit_next   = '0;
                    cnt_next   = '0;
                    row_next   = row_data;
                end
            end
            rlct_pkg::TX_BITS:
            begin
                if (ctrl.tick)
                begin
                    if (cnt_inc < {9'd0, timing.bit_period})
                    begin
                        cnt_next = cnt_inc[rlct_pkg::CNT_W-1:0];
                    end
                    else
                    begin
                        cnt_next = '0;
                        row_next = {row_reg[rlct_pkg::ROW_W-2:0], 1'b0};
                        if (bit_reg == rlct_pkg::BIT_LAST)
                        begin
                            bit_next = '0;
                            if (led_reg == LED_LAST)
                            begin
                                led_next   = '0;
                                row_next   = '0;
                                phase_next = (timing.latch == 16'd0) ?
                                             rlct_pkg::TX_IDLE : rlct_pkg::TX_LATCH;
                            end
                            else
                            begin
                                led_next = led_reg + AW'(1);
                                row_next = row_data;
                            end
                        end
                        else
                        begin
                            bit_next = bit_reg + 5'd1;
                        end
                    end
                end
            end
            rlct_pkg::TX_LATCH:
            begin
                if (ctrl.tick)
                begin
                    if (cnt_inc >= {1'b0, timing.latch})
                    begin
                        cnt_next   = '0;
                        phase_next = rlct_pkg::TX_IDLE;
                    end
                    else
                    begin
                        cnt_next = cnt_inc[rlct_pkg::CNT_W-1:0];
                    end
                end
            end
            default:
            begin
                phase_next = rlct_pkg::TX_IDLE;
            end
        endcase

        high = row_next[rlct_pkg::ROW_W-1] ? timing.one_high : timing.zero_high;
        status.active      = (phase_reg != rlct_pkg::TX_IDLE);
        status.active_next = (phase_next != rlct_pkg::TX_IDLE);
        status.pin_next    = (phase_next == rlct_pkg::TX_BITS) && (cnt_next < {8'd0, high});
    end

    // prefetch the following LED while the current one shifts out
    assign rd_addr = ((phase_reg == rlct_pkg::TX_BITS) && (led_reg != LED_LAST)) ?
                     led_reg + AW'(1) : '0;

endmodule

// ===== rtl/rgb_led_chain_transmitter.sv =====
`timescale 1ns / 1ps
// Top level: command decode, timing registers, clearing pass and result strobe.
// A result strobes on done in the cycle after its command beat is taken.
// Throughput: one beat per cycle for set, update and tick while busy is low; clear
// holds busy while the frame buffer is zeroed one row per cycle.
// Reset: the same clearing pass runs after reset, busy high.
// The receiver cannot stall: each result is shown for exactly one cycle.
module rgb_led_chain_transmitter #(
    parameter int NUM_LEDS = rlct_pkg::NUM_LEDS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [1:0]                 cmd,
    input  logic [6:0]                 led_index,
    input  logic [23:0]                rgb_color,
    input  logic                       cfg_we,
    input  logic [1:0]                 cfg_addr,
    input  logic [rlct_pkg::CFG_W-1:0] cfg_wdata,
    output logic                       done,
    output logic                       data_out,
    output logic                       busy_res,
    output logic                       accepted
);

    localparam int AW = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
    localparam logic [AW-1:0] LED_LAST = AW'(NUM_LEDS - 1);

    rlct_pkg::timing_t           timing_reg, timing_next;
    logic                        sweep_reg, sweep_next;
    logic [AW-1:0]               sweep_idx_reg, sweep_idx_next;
    logic                        done_reg, data_out_reg, busy_res_reg, accepted_reg;

    logic                        beat;
    logic                        set_ok, clr_ok, upd_ok, tick_ok;
    logic                        mem_we;
    logic [AW-1:0]               mem_waddr, mem_raddr;
    logic [rlct_pkg::ROW_W-1:0]  mem_wdata, mem_rdata, row_in;
    rlct_pkg::tx_ctrl_t          tx_ctrl;
    rlct_pkg::tx_status_t        tx_status;
    rlct_pkg::cmd_t              cmd_code;

    assign cmd_code = rlct_pkg::cmd_t'(cmd);
    assign beat     = start && !sweep_reg;
    assign busy     = sweep_reg;

    assign set_ok  = beat && (cmd_code == rlct_pkg::CMD_SET) && !tx_status.active &&
                     ({25'd0, led_index} < 32'(NUM_LEDS));
    assign clr_ok  = beat && (cmd_code == rlct_pkg::CMD_CLEAR) && !tx_status.active;
    assign upd_ok  = beat && (cmd_code == rlct_pkg::CMD_UPDATE) && !tx_status.active;
    assign tick_ok = beat && (cmd_code == rlct_pkg::CMD_TICK);

    // GRB order in the buffer
    assign row_in    = {rgb_color[15:8], rgb_color[23:16], rgb_color[7:0]};
    assign mem_we    = set_ok || sweep_reg;
    assign mem_waddr = sweep_reg ? sweep_idx_reg : AW'(led_index);
    assign mem_wdata = sweep_reg ? '0 : row_in;

    assign tx_ctrl.start = upd_ok;
    assign tx_ctrl.tick  = tick_ok;

    rlct_frame_mem #(
        .DEPTH (NUM_LEDS)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    rlct_tx #(
        .NUM_LEDS (NUM_LEDS)
    ) u_tx (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (tx_ctrl),
        .timing   (timing_reg),
        .row_data (mem_rdata),
        .rd_addr  (mem_raddr),
        .status   (tx_status)
    );

    always_comb
    begin
        timing_next = timing_reg;
        if (cfg_we)
        begin
            case (rlct_pkg::cfg_reg_t'(cfg_addr))
                rlct_pkg::CFG_BIT_PERIOD: timing_next.bit_period = cfg_wdata[7:0];
                rlct_pkg::CFG_ZERO_HIGH:  timing_next.zero_high  = cfg_wdata[7:0];
                rlct_pkg::CFG_ONE_HIGH:   timing_next.one_high   = cfg_wdata[7:0];
                rlct_pkg::CFG_LATCH:      timing_next.latch      = cfg_wdata;
                default:                  timing_next = timing_reg;
            endcase
        end
    end

    always_comb
    begin
        sweep_next     = sweep_reg;
        sweep_idx_next = sweep_idx_reg;
        if (sweep_reg)
        begin
            if (sweep_idx_reg == LED_LAST)
            begin
                sweep_next     = 1'b0;
                sweep_idx_next = '0;
            end
            else
            begin
                sweep_idx_next = sweep_idx_reg + AW'(1);
            end
        end
        else if (clr_ok)
        begin
            sweep_next     = 1'b1;
            sweep_idx_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timing_reg.bit_period <= rlct_pkg::BIT_PERIOD_RST;
            timing_reg.zero_high  <= rlct_pkg::ZERO_HIGH_RST;
            timing_reg.one_high   <= rlct_pkg::ONE_HIGH_RST;
            timing_reg.latch      <= rlct_pkg::LATCH_RST;
            sweep_reg             <= 1'b1;
            sweep_idx_reg         <= '0;
            done_reg              <= 1'b0;
            data_out_reg          <= 1'b0;
            busy_res_reg          <= 1'b0;
            accepted_reg          <= 1'b0;
        end
        else
        begin
            timing_reg    <= timing_next;
            sweep_reg     <= sweep_next;
            sweep_idx_reg <= sweep_idx_next;
            done_reg      <= beat;
            data_out_reg  <= tx_status.pin_next;
            busy_res_reg  <= tx_status.active_next;
            accepted_reg  <= set_ok || clr_ok || upd_ok || tick_ok;
        end
    end

    assign done     = done_reg;
    assign data_out = data_out_reg;
    assign busy_res = busy_res_reg;
    assign accepted = accepted_reg;

    a_done_follows_beat: assert property (@(posedge clk) disable iff (!rst_n)
        beat |=> done)
        else $error("result strobe missing after a command beat");

    a_refused_while_sending: assert property (@(posedge clk) disable iff (!rst_n)
        beat && (cmd_code != rlct_pkg::CMD_TICK) && tx_status.active |=> !accepted)
        else $error("command carried out during a frame");

    a_pin_low_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done && !busy_res |-> !data_out)
        else $error("pin high outside a frame");

    a_clear_starts_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        clr_ok |=> busy)
        else $error("clear did not start the clearing pass");

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the RGB LED chain transmitter: queued driver, monitor, predictor.
module tb_top;

    localparam int CHAIN_LEDS  = rlct_pkg::NUM_LEDS_DEF;
    localparam int FRAME_BYTES = 3 * CHAIN_LEDS;
    localparam int STALL_LIMIT = 1000;

    typedef struct {
        rlct_pkg::cmd_t op;
        logic [6:0]     led;
        logic [23:0]    color;
        int unsigned    gap;
    } led_cmd_t;

    typedef struct {
        logic pin;
        logic active;
        logic acc;
    } pin_result_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        start     = 1'b0;
    logic        busy;
    logic [1:0]  cmd       = rlct_pkg::CMD_TICK;
    logic [6:0]  led_index = '0;
    logic [23:0] rgb_color = '0;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_addr  = rlct_pkg::CFG_BIT_PERIOD;
    logic [rlct_pkg::CFG_W-1:0] cfg_wdata = '0;
    logic        done;
    logic        data_out;
    logic        busy_res;
    logic        accepted;

    rgb_led_chain_transmitter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .led_index (led_index),
        .rgb_color (rgb_color),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .done      (done),
        .data_out  (data_out),
        .busy_res  (busy_res),
        .accepted  (accepted)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // predictor state
    logic [7:0]           frame_mem [0:FRAME_BYTES-1];
    rlct_pkg::timing_t    m_timing;
    rlct_pkg::tx_phase_t  m_phase;
    logic [8:0]           m_byte;
    logic [2:0]           m_bit;
    int unsigned          m_count;
    logic [7:0]           m_shift;

    led_cmd_t    cmd_backlog [$];
    pin_result_t pin_expect_q [$];
    led_cmd_t    cur_cmd;
    logic        have_cur  = 1'b0;
    int unsigned hold_left = 0;
    int unsigned mismatches = 0;
    int unsigned stall_cycles = 0;
    logic        calm_stretch = 1'b0;

    function automatic void model_reset();
        for (int i = 0; i < FRAME_BYTES; i++)
            frame_mem[i] = 8'h00;
        m_timing.bit_period = rlct_pkg::BIT_PERIOD_RST;
        m_timing.zero_high  = rlct_pkg::ZERO_HIGH_RST;
        m_timing.one_high   = rlct_pkg::ONE_HIGH_RST;
        m_timing.latch      = rlct_pkg::LATCH_RST;
        m_phase = rlct_pkg::TX_IDLE;
        m_byte  = '0;
        m_bit   = '0;
        m_count = 0;
        m_shift = '0;
    endfunction

    function automatic void advance_waveform();
        if (m_phase == rlct_pkg::TX_BITS)
        begin
            m_count++;
            if (m_count >= m_timing.bit_period)
            begin
                m_count = 0;
                m_shift = m_shift << 1;
                m_bit   = m_bit + 3'd1;
                if (m_bit == 3'd0)
                begin
                    if (m_byte == FRAME_BYTES - 1)
                    begin
                        m_byte  = '0;
                        m_shift = '0;
                        m_phase = (m_timing.latch == 16'd0) ? rlct_pkg::TX_IDLE
                                                            : rlct_pkg::TX_LATCH;
                    end
                    else
                    begin
                        m_byte  = m_byte + 9'd1;
                        m_shift = frame_mem[m_byte];
                    end
                end
            end
        end
        else if (m_phase == rlct_pkg::TX_LATCH)
        begin
            m_count++;
            if (m_count >= m_timing.latch)
            begin
                m_count = 0;
                m_phase = rlct_pkg::TX_IDLE;
            end
        end
    endfunction

    function automatic pin_result_t led_chain_step(led_cmd_t c);
        pin_result_t r;
        logic [7:0]  high;
        int unsigned base;
        r.acc = 1'b0;
        if (c.op == rlct_pkg::CMD_TICK)
        begin
            advance_waveform();
            r.acc = 1'b1;
        end
        else if (m_phase == rlct_pkg::TX_IDLE)
        begin
            case (c.op)
                rlct_pkg::CMD_SET:
                begin
                    if (c.led < CHAIN_LEDS)
                    begin
                        base = 3 * c.led;
                        frame_mem[base]     = c.color[15:8];
                        frame_mem[base + 1] = c.color[23:16];
                        frame_mem[base + 2] = c.color[7:0];
                        r.acc = 1'b1;
                    end
                end
                rlct_pkg::CMD_CLEAR:
                begin
                    for (int i = 0; i < FRAME_BYTES; i++)
                        frame_mem[i] = 8'h00;
                    r.acc = 1'b1;
                end
                default:
                begin
                    m_byte  = '0;
                    m_bit   = '0;
                    m_count = 0;
                    m_shift = frame_mem[0];
                    m_phase = rlct_pkg::TX_BITS;
                    r.acc   = 1'b1;
                end
            endcase
        end
        high     = m_shift[7] ? m_timing.one_high : m_timing.zero_high;
        r.pin    = (m_phase == rlct_pkg::TX_BITS) && (m_count < high);
        r.active = (m_phase != rlct_pkg::TX_IDLE);
        return r;
    endfunction

    // driver: one beat per accepted edge, per-item gap before start rises
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                pin_expect_q.push_back(led_chain_step(cur_cmd));
                have_cur = 1'b0;
            end
            if (!have_cur && cmd_backlog.size() != 0)
            begin
                cur_cmd   = cmd_backlog.pop_front();
                have_cur  = 1'b1;
                hold_left = cur_cmd.gap;
            end
            if (have_cur && hold_left == 0)
            begin
                start     <= 1'b1;
                cmd       <= cur_cmd.op;
                led_index <= cur_cmd.led;
                rgb_color <= cur_cmd.color;
            end
            else
            begin
                start <= 1'b0;
                if (have_cur)
                    hold_left--;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        pin_result_t want;
        if (rst_n && done)
        begin
            if (pin_expect_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: pin=%0b busy=%0b acc=%0b",
                             data_out, busy_res, accepted);
            end
            else
            begin
                want = pin_expect_q.pop_front();
                if (data_out !== want.pin || busy_res !== want.active
                    || accepted !== want.acc)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp pin=%0b busy=%0b acc=%0b, ",
                                  "got pin=%0b busy=%0b acc=%0b"},
                                 want.pin, want.active, want.acc,
                                 data_out, busy_res, accepted);
                end
            end
        end
    end

    // watchdog on cycles with no beat and no result
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles == STALL_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic int unsigned draw_gap();
        return calm_stretch ? 0 : $urandom_range(0, 6);
    endfunction

    function automatic int unsigned drain_gap();
        return ($urandom_range(0, 15) == 0) ? $urandom_range(0, 6) : 0;
    endfunction

    function automatic void push_cmd(rlct_pkg::cmd_t op, logic [6:0] led, logic [23:0] color,
                                     int unsigned gap);
        led_cmd_t c;
        c.op    = op;
        c.led   = led;
        c.color = color;
        c.gap   = gap;
        cmd_backlog.push_back(c);
    endfunction

    task automatic wait_quiet();
        while (cmd_backlog.size() != 0 || have_cur || pin_expect_q.size() != 0 || busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(rlct_pkg::cfg_reg_t r, logic [15:0] v);
        cfg_we    <= 1'b1;
        cfg_addr  <= r;
        cfg_wdata <= v;
        case (r)
            rlct_pkg::CFG_BIT_PERIOD: m_timing.bit_period = v[7:0];
            rlct_pkg::CFG_ZERO_HIGH:  m_timing.zero_high  = v[7:0];
            rlct_pkg::CFG_ONE_HIGH:   m_timing.one_high   = v[7:0];
            default:                  m_timing.latch      = v;
        endcase
        @(posedge clk);
    endtask

    task automatic load_timing(logic [7:0] bp, logic [7:0] zh, logic [7:0] oh,
                               logic [15:0] lt);
        write_reg(rlct_pkg::CFG_BIT_PERIOD, {8'h00, bp});
        write_reg(rlct_pkg::CFG_ZERO_HIGH, {8'h00, zh});
        write_reg(rlct_pkg::CFG_ONE_HIGH, {8'h00, oh});
        write_reg(rlct_pkg::CFG_LATCH, lt);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // send ticks until the frame and its latch period are over
    task automatic drain_frame();
        wait_quiet();
        while (m_phase != rlct_pkg::TX_IDLE)
        begin
            if (cmd_backlog.size() < 16)
                push_cmd(rlct_pkg::CMD_TICK, '0, '0, drain_gap());
            @(posedge clk);
        end
        wait_quiet();
    endtask

    // mostly set/update/tick bursts, the rest random noise
    task automatic run_random(int unsigned n);
        int unsigned sent;
        int unsigned cnt;
        logic [6:0]  led;
        sent = 0;
        while (sent < n)
        begin
            calm_stretch = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) < 7)
            begin
                cnt = $urandom_range(1, 4);
                for (int i = 0; i < cnt; i++)
                begin
                    led = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(0, 127))
                                                      : 7'($urandom_range(0, 3));
                    push_cmd(rlct_pkg::CMD_SET, led, 24'($urandom), draw_gap());
                end
                push_cmd(rlct_pkg::CMD_UPDATE, 7'($urandom), 24'($urandom), draw_gap());
                cnt = cnt + 1 + $urandom_range(4, 40);
                for (int i = 0; i < cnt - 5; i++)
                    push_cmd(rlct_pkg::CMD_TICK, 7'($urandom), 24'($urandom), draw_gap());
                sent += cnt;
            end
            else
            begin
                cnt = $urandom_range(1, 6);
                for (int i = 0; i < cnt; i++)
                    push_cmd(rlct_pkg::cmd_t'($urandom_range(0, 3)), 7'($urandom),
                             24'($urandom), draw_gap());
                sent += cnt;
            end
        end
        calm_stretch = 1'b0;
    endtask

    initial
    begin
        model_reset();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        wait_quiet();

        // directed: reset timing, index extremes, refused commands while sending
        push_cmd(rlct_pkg::CMD_TICK, 7'd0, 24'h000000, draw_gap());
        push_cmd(rlct_pkg::CMD_SET, 7'd0, 24'hFFFFFF, draw_gap());
        push_cmd(rlct_pkg::CMD_SET, 7'd127, 24'h000000, draw_gap());
        push_cmd(rlct_pkg::CMD_SET, 7'd127, 24'hFFFFFF, draw_gap());
        push_cmd(rlct_pkg::CMD_SET, 7'd1, 24'hA5C33C, draw_gap());
        push_cmd(rlct_pkg::CMD_CLEAR, 7'd127, 24'hFFFFFF, draw_gap());
        push_cmd(rlct_pkg::CMD_SET, 7'd0, 24'h8001FF, draw_gap());
        push_cmd(rlct_pkg::CMD_SET, 7'd1, 24'h5A00C3, draw_gap());
        push_cmd(rlct_pkg::CMD_UPDATE, 7'd0, 24'h000000, draw_gap());
        push_cmd(rlct_pkg::CMD_SET, 7'd2, 24'h123456, draw_gap());
        push_cmd(rlct_pkg::CMD_CLEAR, 7'd0, 24'h000000, draw_gap());
        push_cmd(rlct_pkg::CMD_UPDATE, 7'd0, 24'h000000, draw_gap());
        for (int i = 0; i < 13; i++)
            push_cmd(rlct_pkg::CMD_TICK, 7'd0, 24'h000000, draw_gap());
        run_random(150);
        wait_quiet();

        // finish the running frame at one tick per bit, no latch period
        load_timing(8'd1, 8'd255, 8'd0, 16'h0000);
        drain_frame();

        load_timing(8'd2, 8'd1, 8'd2, 16'h0000);
        run_random(150);
        wait_quiet();

        // short bit period and a short latch period to end the frame
        load_timing(8'd0, 8'd0, 8'd255, 16'h0007);
        drain_frame();

        begin
            logic [7:0] bp;
            bp = 8'($urandom_range(2, 5));
            load_timing(bp, 8'($urandom_range(0, bp + 1)), 8'($urandom_range(0, bp + 1)),
                        16'($urandom_range(0, 300)));
        end
        run_random(200);
        wait_quiet();

        load_timing(8'd255, 8'd1, 8'd255, 16'hFFFF);
        run_random(150);
        wait_quiet();
        repeat (16) @(posedge clk);

        if (mismatches == 0 && pin_expect_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/rlct_pkg.sv
rtl/rlct_frame_mem.sv
rtl/rlct_tx.sv
rtl/rgb_led_chain_transmitter.sv
dv/tb_top.sv
